### design/key_press_duration_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// Key press duration classifier: assertion macros
// Shared concurrent assertion forms used by the classifier modules.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KPDC_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define KPDC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/kpdc_pkg.sv
// ----------------------------------------------------------------------------
// Key press duration classifier package
// Types, register indexes, event codes and reset constants.
// ----------------------------------------------------------------------------
package kpdc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SHORT     = 2'd0;
    localparam logic [1:0] REG_LONG      = 2'd1;
    localparam logic [1:0] REG_LONG_LONG = 2'd2;

    localparam logic [7:0] SHORT_RST     = 8'd2;
    localparam logic [7:0] LONG_RST      = 8'h40;
    localparam logic [7:0] LONG_LONG_RST = 8'hAF;

    // counter is clamped here before increment, so it tops out one above
    localparam logic [7:0] HOLD_CLAMP    = 8'hEE;
    localparam logic [7:0] HOLD_MAX      = 8'hEF;

    // level codes
    localparam logic [1:0] LVL_PRESS     = 2'd0;
    localparam logic [1:0] LVL_LONG      = 2'd1;
    localparam logic [1:0] LVL_LONG_LONG = 2'd2;

    // event codes
    localparam logic [2:0] EV_PRESS      = 3'd0;
    localparam logic [2:0] EV_REL_PRESS  = 3'd3;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = 2;

    typedef struct packed {
        logic [7:0] short_thr;
        logic [7:0] long_thr;
        logic [7:0] long_long_thr;
    } thr_t;

    typedef struct packed {
        logic [2:0] trig;     // bit l: level l triggered this tick
        logic       rel;      // release event this tick
        logic [1:0] rel_top;  // highest level reached, for the release
    } lane_ev_t;

    typedef struct packed {
        logic [2:0] key;
        logic [2:0] kind;
        logic       last;
    } evq_entry_t;

    typedef struct packed {
        logic [1:0] n;        // entries to push: 0, 1 or 2
        evq_entry_t ent0;
        evq_entry_t ent1;
    } evq_push_t;

endpackage

### design/kpdc_lane.sv
// ----------------------------------------------------------------------------
// Key lane
// Hold counter and level flags of one key; computes the key's events per tick.
// ----------------------------------------------------------------------------
`include "key_press_duration_classifier_top_defines.svh"

module kpdc_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                pressed,
    input  kpdc_pkg::thr_t      thr,
    output kpdc_pkg::lane_ev_t  ev
);

    logic [7:0] hold_reg, hold_next;
    logic [2:0] flags_reg, flags_next;
    logic [7:0] hold_cur;
    logic [2:0] flags_trig;
    logic       above;

    always_comb begin
        if (pressed) begin
            hold_cur = ((hold_reg > kpdc_pkg::HOLD_CLAMP) ? kpdc_pkg::HOLD_CLAMP : hold_reg)
                       + 8'd1;
        end else begin
            hold_cur = hold_reg;
        end
        above = hold_cur > thr.short_thr;
        ev.trig[0] = above && !flags_reg[0];
        ev.trig[1] = above && (hold_cur > thr.long_thr) && !flags_reg[1];
        ev.trig[2] = above && (hold_cur > thr.long_long_thr) && !flags_reg[2];
        flags_trig = flags_reg | ev.trig;
        ev.rel     = !pressed && (flags_trig != 3'b000);
        if (flags_trig[2]) begin
            ev.rel_top = kpdc_pkg::LVL_LONG_LONG;
        end else if (flags_trig[1]) begin
            ev.rel_top = kpdc_pkg::LVL_LONG;
        end else begin
            ev.rel_top = kpdc_pkg::LVL_PRESS;
        end
        // a released key triggers on its old count, then clears
        hold_next  = pressed ? hold_cur : 8'd0;
        flags_next = pressed ? flags_trig : 3'b000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= 8'd0;
            flags_reg <= 3'b000;
        end else if (step) begin
            hold_reg  <= hold_next;
            flags_reg <= flags_next;
        end
    end

    `KPDC_ASSERT_NOW(a_hold_sat, aclk, aresetn, 1'b1, hold_reg <= kpdc_pkg::HOLD_MAX)
    `KPDC_ASSERT_NOW(a_flag_order, aclk, aresetn, flags_reg[2] || flags_reg[1], flags_reg[0])
    `KPDC_ASSERT_NEXT(a_rel_clear, aclk, aresetn, step && !pressed,
                      hold_reg == 8'd0 && flags_reg == 3'b000)

endmodule

### design/kpdc_merge.sv
// ----------------------------------------------------------------------------
// Event merge
// Registers the lanes' events and picks the first two in tick order.
// ----------------------------------------------------------------------------
module kpdc_merge #(
    parameter int NUM_KEYS = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  kpdc_pkg::lane_ev_t  lane_ev [NUM_KEYS],
    input  logic                q_room,
    output logic                ready,
    output kpdc_pkg::evq_push_t push
);

    logic               stage_valid_reg, stage_valid_next;
    kpdc_pkg::lane_ev_t stage_ev_reg [NUM_KEYS];
    logic               drain;
    logic [1:0]         cnt;
    kpdc_pkg::evq_entry_t e0, e1;

    assign drain = stage_valid_reg && q_room;
    assign ready = !stage_valid_reg || q_room;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (load) begin
            stage_valid_next = 1'b1;
        end else if (drain) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                stage_ev_reg[k] <= lane_ev[k];
            end
        end
    end

    // triggers in key then level order, then releases in key order
    always_comb begin
        kpdc_pkg::evq_entry_t ent;
        cnt = 2'd0;
        e0  = '0;
        e1  = '0;
        ent = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (stage_ev_reg[k].trig[l]) begin
                    ent.key  = 3'(k);
                    ent.kind = kpdc_pkg::EV_PRESS + 3'(l);
                    ent.last = 1'b0;
                    if (cnt == 2'd0) begin
                        e0 = ent;
                    end else if (cnt == 2'd1) begin
                        e1 = ent;
                    end
                    if (cnt != 2'd2) begin
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (stage_ev_reg[k].rel) begin
                ent.key  = 3'(k);
                ent.kind = kpdc_pkg::EV_REL_PRESS + {1'b0, stage_ev_reg[k].rel_top};
                ent.last = 1'b0;
                if (cnt == 2'd0) begin
                    e0 = ent;
                end else if (cnt == 2'd1) begin
                    e1 = ent;
                end
                if (cnt != 2'd2) begin
                    cnt = cnt + 2'd1;
                end
            end
        end
        e0.last   = (cnt == 2'd1);
        e1.last   = 1'b1;
        push.n    = drain ? cnt : 2'd0;
        push.ent0 = e0;
        push.ent1 = e1;
    end

endmodule

### design/kpdc_evq.sv
// ----------------------------------------------------------------------------
// Event queue
// Four-entry result queue taking up to two events per cycle while it has room for two.
// ----------------------------------------------------------------------------
`include "key_press_duration_classifier_top_defines.svh"

module kpdc_evq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kpdc_pkg::evq_push_t  push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kpdc_pkg::evq_entry_t head
);

    localparam int CW = kpdc_pkg::EVQ_AW + 1;

    kpdc_pkg::evq_entry_t mem [kpdc_pkg::EVQ_DEPTH];
    logic [kpdc_pkg::EVQ_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != '0;
    assign room    = count_reg <= CW'(kpdc_pkg::EVQ_DEPTH - 2);
    assign head    = mem[rd_reg];

    always_comb begin
        wr_next    = wr_reg + kpdc_pkg::EVQ_AW'(push.n);
        rd_next    = rd_reg + kpdc_pkg::EVQ_AW'(pop);
        count_next = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_reg] <= push.ent0;
        end
        if (push.n == 2'd2) begin
            mem[wr_reg + kpdc_pkg::EVQ_AW'(1)] <= push.ent1;
        end
    end

    `KPDC_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1,
                     count_reg <= CW'(kpdc_pkg::EVQ_DEPTH))
    `KPDC_ASSERT_NOW(a_push_room, aclk, aresetn, push.n != 2'd0, room)
    `KPDC_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && push.n == 2'd0,
                      count_reg == $past(count_reg) - CW'(1))

endmodule

### design/key_press_duration_classifier_top.sv
// ----------------------------------------------------------------------------
// Key press duration classifier top level
// Per-key hold lanes, an event merge stage and a result queue.
//
//   channel | ports                                  | carries
//   --------+----------------------------------------+------------------------
//   input   | s_valid s_ready s_key_levels           | one scan tick
//   result  | m_valid m_ready m_key_index            | one event per transfer
//           | m_event_kind m_last_event              |
//   config  | cfg_valid cfg_ready cfg_index cfg_data | threshold write
//
// A tick is taken every cycle while the merge stage is empty or can drain into
// the queue; it yields at most the first two of its events, sent one per cycle
// while m_ready is high. m_valid rises once the tick's events have passed the
// merge stage register and been written into the queue.
// Reset (synchronous) clears counters, flags and queue and loads the default
// thresholds. A stalled m_ready backs up the queue and then s_ready.
// ----------------------------------------------------------------------------
module key_press_duration_classifier_top #(
    parameter int NUM_KEYS = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_key_levels,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_key_index,
    output logic [2:0] m_event_kind,
    output logic       m_last_event,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    kpdc_pkg::thr_t       thr_reg;
    kpdc_pkg::lane_ev_t   lane_ev [NUM_KEYS];
    kpdc_pkg::evq_push_t  push;
    kpdc_pkg::evq_entry_t head;
    logic                 step;
    logic                 merge_ready;
    logic                 q_room;

    assign cfg_ready = 1'b1;
    assign s_ready   = merge_ready;
    assign step      = s_valid && merge_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.short_thr     <= kpdc_pkg::SHORT_RST;
            thr_reg.long_thr      <= kpdc_pkg::LONG_RST;
            thr_reg.long_long_thr <= kpdc_pkg::LONG_LONG_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kpdc_pkg::REG_SHORT:     thr_reg.short_thr     <= cfg_data;
                kpdc_pkg::REG_LONG:      thr_reg.long_thr      <= cfg_data;
                kpdc_pkg::REG_LONG_LONG: thr_reg.long_long_thr <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kpdc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .pressed (!s_key_levels[k]),
            .thr     (thr_reg),
            .ev      (lane_ev[k])
        );
    end

    kpdc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .lane_ev (lane_ev),
        .q_room  (q_room),
        .ready   (merge_ready),
        .push    (push)
    );

    kpdc_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (q_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_key_index  = head.key;
    assign m_event_kind = head.kind;
    assign m_last_event = head.last;

endmodule
